@@ rtl/aam_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aam_pkg: shared types and constants of the auto-ranging amplitude meter
// Request and register codes, field widths and the window report layout.
// ----------------------------------------------------------------------------
package aam_pkg;

	localparam int ADC_BITS_DEF = 10;
	localparam int CH_COUNT     = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int SAT_W      = 10;
	localparam int GND_W      = 10;
	localparam int IGN_W      = 8;
	localparam int IDX_W      = 3;
	localparam int CNT_W      = 8;
	localparam int PK_W       = 16;
	localparam int SUM_W      = 32;
	localparam int REP_W      = 8;
	localparam int REQ_W      = 3;

	localparam int REPORT_DATA_W = PK_W + SUM_W + SUM_W + REP_W;

	// request kinds carried in the input tuser
	typedef enum logic [REQ_W-1:0] {
		REQ_SAMPLE = 3'd0,
		REQ_BEGIN  = 3'd1,
		REQ_OPEN   = 3'd2,
		REQ_CLOSE  = 3'd3,
		REQ_FINISH = 3'd4
	} req_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAT_HIGH  = 3'd0,
		CFG_SAT_LOW   = 3'd1,
		CFG_IGNORE    = 3'd2,
		CFG_RMS_MODE  = 3'd3,
		CFG_HV_TOP    = 3'd4,
		CFG_FB_TOP    = 3'd5,
		CFG_HV_GROUND = 3'd6,
		CFG_FB_GROUND = 3'd7
	} cfg_idx_t;

	// one window report; the data part packs peak_to_peak in the lowest bits
	typedef struct packed {
		logic                    last;
		logic                    out_channel;
		logic signed [REP_W-1:0] range_report;
		logic [SUM_W-1:0]        square_sum;
		logic [SUM_W-1:0]        sample_sum;
		logic [PK_W-1:0]         peak_to_peak;
	} report_t;

endpackage

@@ rtl/autorange_amplitude_meter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autorange_amplitude_meter_unit: two-channel auto-ranging amplitude meter
// Tracks saturation, min/max or sums per channel and reports each window.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream: tuser holds the request kind and the channel, tdata the ADC
//  sample. Sample, begin, open and finish requests update internal state only;
//  a close-window request pushes two reports (channel 0, then channel 1 with
//  tlast set) into a four-entry result queue on the output stream.
//  An accepted item is registered and processed once the queue has room for
//  two reports; its reports are written into the queue and shown from there.
//  Throughput: one item per cycle while the queue has room for two reports.
//  Sustained close-window traffic is bounded by the output port, which drains
//  one report per cycle while the receiver is ready, two per such item.
//  When the receiver stalls, the queue fills and input tready drops once
//  fewer than two entries are free; nothing is lost or reordered.
//  Reset clears all per-channel state (min_q goes to the largest ADC code)
//  and loads the register defaults. Configuration writes are always taken and
//  should only be issued while the meter is idle.
// ----------------------------------------------------------------------------
module autorange_amplitude_meter_unit
	import aam_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: [ADC_BITS-1:0] sample, rest zero
	input  logic [((ADC_BITS+7)/8)*8-1:0]     s_axis_tdata,
	// tuser: [2:0] req_type, [3] channel
	input  logic [REQ_W:0]                    s_axis_tuser,
	// output stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata: [15:0] peak_to_peak, [47:16] sample_sum, [79:48] square_sum,
	//        [87:80] range_report
	output logic [REPORT_DATA_W-1:0]          m_axis_tdata,
	// tuser: [0] out_channel
	output logic [0:0]                        m_axis_tuser,
	output logic                              m_axis_tlast,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [CFG_IDX_W-1:0]              cfg_index,
	input  logic [CFG_DATA_W-1:0]             cfg_data
);

	localparam int CMP_W = (ADC_BITS > SAT_W) ? ADC_BITS : SAT_W;
	localparam logic [ADC_BITS-1:0] ADC_MAX = '1;
	localparam logic [SUM_W-1:0] SMALL_PK = SUM_W'((64 * ((1 << ADC_BITS) - 1)) / 20);
	localparam int Q_DEPTH = 4;
	localparam int QP_W = $clog2(Q_DEPTH);
	localparam int QC_W = $clog2(Q_DEPTH + 1);

	// configuration registers
	logic [SAT_W-1:0] sat_high_q;
	logic [SAT_W-1:0] sat_low_q;
	logic [IGN_W-1:0] ign_after_q;
	logic             rms_mode_q;
	logic [IDX_W-1:0] top_q [CH_COUNT];
	logic [GND_W-1:0] ground_q [CH_COUNT];

	// input register
	logic                in_valid_s1;
	req_t                in_req_s1;
	logic                in_chan_s1;
	logic [ADC_BITS-1:0] in_sample_s1;

	// result queue
	report_t         q_mem [Q_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;

	report_t rep_c [CH_COUNT];

	logic room;
	logic advance;
	logic push;
	logic pop;

	// take configuration writes at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_high_q  <= SAT_W'(1013);
			sat_low_q   <= SAT_W'(10);
			ign_after_q <= IGN_W'(1);
			rms_mode_q  <= 1'b0;
			top_q[0]    <= IDX_W'(2);
			top_q[1]    <= IDX_W'(4);
			ground_q[0] <= GND_W'(512);
			ground_q[1] <= GND_W'(512);
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SAT_HIGH:  sat_high_q  <= cfg_data[SAT_W-1:0];
				CFG_SAT_LOW:   sat_low_q   <= cfg_data[SAT_W-1:0];
				CFG_IGNORE:    ign_after_q <= cfg_data[IGN_W-1:0];
				CFG_RMS_MODE:  rms_mode_q  <= cfg_data[0];
				CFG_HV_TOP:    top_q[0]    <= cfg_data[IDX_W-1:0];
				CFG_FB_TOP:    top_q[1]    <= cfg_data[IDX_W-1:0];
				CFG_HV_GROUND: ground_q[0] <= cfg_data[GND_W-1:0];
				CFG_FB_GROUND: ground_q[1] <= cfg_data[GND_W-1:0];
				default: ;
			endcase
		end
	end

	// process the registered item once the queue can take two reports
	assign room          = count_q <= QC_W'(Q_DEPTH - 2);
	assign advance       = in_valid_s1 && room;
	assign s_axis_tready = !in_valid_s1 || room;
	assign push          = advance && (in_req_s1 == REQ_CLOSE);
	assign pop           = m_axis_tvalid && m_axis_tready;

	// capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_req_s1    <= req_t'(s_axis_tuser[REQ_W-1:0]);
			in_chan_s1   <= s_axis_tuser[REQ_W];
			in_sample_s1 <= s_axis_tdata[ADC_BITS-1:0];
		end
	end

	// per-channel measurement state
	for (genvar c = 0; c < CH_COUNT; c++) begin : g_chan
		logic [IDX_W-1:0]    range_q, range_d;
		logic [IDX_W-1:0]    saved_q, saved_d;
		logic [CNT_W-1:0]    satc_q, satc_d;
		logic [IGN_W-1:0]    ign_q, ign_d;
		logic [ADC_BITS-1:0] max_q, max_d;
		logic [ADC_BITS-1:0] min_q, min_d;
		logic [SUM_W-1:0]    sum_q, sum_d;
		logic [SUM_W-1:0]    sqs_q, sqs_d;

		logic                sel;
		logic [CMP_W-1:0]    smp_ext;
		logic [CMP_W-1:0]    gnd_ext;
		logic [CMP_W-1:0]    dev;
		logic [2*CMP_W-1:0]  dev_sq;
		logic                sat;
		logic                down_ok;
		logic [IDX_W:0]      up_idx;
		logic                up_ok;
		logic [ADC_BITS-1:0] span;
		logic [PK_W-1:0]     pk;
		logic [CNT_W-1:0]    clamp;
		logic [REP_W-1:0]    rep;

		assign sel     = in_chan_s1 == 1'(c);
		assign smp_ext = CMP_W'(in_sample_s1);
		assign gnd_ext = CMP_W'(ground_q[c]);
		assign sat     = (smp_ext > CMP_W'(sat_high_q)) || (smp_ext < CMP_W'(sat_low_q));
		assign dev     = (smp_ext >= gnd_ext) ? smp_ext - gnd_ext : gnd_ext - smp_ext;
		assign dev_sq  = dev * dev;

		// index steps, each kept only within the top index
		assign down_ok = (range_q != '0) && ((range_q - IDX_W'(1)) <= top_q[c]);
		assign up_idx  = {1'b0, range_q} + (IDX_W+1)'(1);
		assign up_ok   = up_idx <= {1'b0, top_q[c]};

		// report fields
		assign span  = max_q - min_q;
		assign pk    = (rms_mode_q || (max_q < min_q)) ? '0 : PK_W'({span, 6'b0});
		assign clamp = (satc_q > CNT_W'(128)) ? CNT_W'(128) : satc_q;
		assign rep   = (satc_q != '0) ? REP_W'(0) - REP_W'(clamp) : REP_W'(range_q);

		assign rep_c[c].last         = (c == CH_COUNT - 1);
		assign rep_c[c].out_channel  = 1'(c);
		assign rep_c[c].range_report = rep;
		assign rep_c[c].square_sum   = sqs_q;
		assign rep_c[c].sample_sum   = sum_q;
		assign rep_c[c].peak_to_peak = pk;

		// next state for the item being processed
		always_comb begin
			range_d = range_q;
			saved_d = saved_q;
			satc_d  = satc_q;
			ign_d   = ign_q;
			max_d   = max_q;
			min_d   = min_q;
			sum_d   = sum_q;
			sqs_d   = sqs_q;
			if (advance) begin
				unique case (in_req_s1)
					REQ_SAMPLE: begin
						if (sel) begin
							if (sat) begin
								if (ign_q == '0) begin
									if (satc_q != '1) begin
										satc_d = satc_q + CNT_W'(1);
									end
									if (down_ok) begin
										range_d = range_q - IDX_W'(1);
									end
									ign_d = ign_after_q;
								end else begin
									ign_d = ign_q - IGN_W'(1);
								end
							end else if (rms_mode_q) begin
								sqs_d = sqs_q + SUM_W'(dev_sq);
								sum_d = sum_q + SUM_W'(in_sample_s1);
							end else begin
								if (in_sample_s1 > max_q) begin
									max_d = in_sample_s1;
								end
								if (in_sample_s1 < min_q) begin
									min_d = in_sample_s1;
								end
							end
						end
					end
					REQ_BEGIN: begin
						saved_d = range_q;
						range_d = top_q[c];
					end
					REQ_OPEN: begin
						satc_d = '0;
						ign_d  = '0;
						if (rms_mode_q) begin
							sum_d = '0;
							sqs_d = '0;
						end else begin
							min_d = ADC_MAX;
							max_d = '0;
						end
					end
					REQ_CLOSE: begin
						if (up_ok && ({{(SUM_W-PK_W){1'b0}}, pk} < SMALL_PK)) begin
							range_d = up_idx[IDX_W-1:0];
						end
					end
					REQ_FINISH: begin
						if (saved_q <= top_q[c]) begin
							range_d = saved_q;
						end
					end
					default: ;
				endcase
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				range_q <= '0;
				saved_q <= '0;
				satc_q  <= '0;
				ign_q   <= '0;
				max_q   <= '0;
				min_q   <= ADC_MAX;
				sum_q   <= '0;
				sqs_q   <= '0;
			end else begin
				range_q <= range_d;
				saved_q <= saved_d;
				satc_q  <= satc_d;
				ign_q   <= ign_d;
				max_q   <= max_d;
				min_q   <= min_d;
				sum_q   <= sum_d;
				sqs_q   <= sqs_d;
			end
		end
	end

	// write both reports of a close window
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q]            <= rep_c[0];
			q_mem[wr_ptr_q + QP_W'(1)] <= rep_c[1];
		end
	end

	// advance queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QP_W'(CH_COUNT);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			end
			count_q <= count_q + (push ? QC_W'(CH_COUNT) : '0) - (pop ? QC_W'(1) : '0);
		end
	end

	// present the oldest report
	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tdata  = {q_mem[rd_ptr_q].range_report, q_mem[rd_ptr_q].square_sum,
		q_mem[rd_ptr_q].sample_sum, q_mem[rd_ptr_q].peak_to_peak};
	assign m_axis_tuser  = q_mem[rd_ptr_q].out_channel;
	assign m_axis_tlast  = q_mem[rd_ptr_q].last;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the auto-ranging amplitude meter
// Sends directed and random request streams with random idle cycles on both
// stream sides, predicts every window report and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import aam_pkg::*;

	localparam int IN_DATA_W  = ((ADC_BITS_DEF + 7) / 8) * 8;
	localparam int ADC_MAX    = (1 << ADC_BITS_DEF) - 1;
	localparam int SMALL_PK   = (64 * ADC_MAX) / 20;
	localparam int SETTLE     = 8;
	localparam int MAX_GAP    = 10;
	localparam int IDLE_LIMIT = 2000;
	localparam int LOG_LIMIT  = 200;
	localparam int PHASE_LEN  = 55;

	// mirror of the meter state and the queue of reports it must produce
	class meter_scoreboard;
		logic [SAT_W-1:0]        sat_high, sat_low;
		logic [IGN_W-1:0]        ignore_len;
		logic                    rms;
		logic [IDX_W-1:0]        top_idx[CH_COUNT];
		logic [GND_W-1:0]        ground[CH_COUNT];
		logic [IDX_W-1:0]        range_idx[CH_COUNT];
		logic [IDX_W-1:0]        saved_idx[CH_COUNT];
		logic [CNT_W-1:0]        sat_count[CH_COUNT];
		logic [CNT_W-1:0]        skip_count[CH_COUNT];
		logic [ADC_BITS_DEF-1:0] max_seen[CH_COUNT];
		logic [ADC_BITS_DEF-1:0] min_seen[CH_COUNT];
		logic [SUM_W-1:0]        sum[CH_COUNT];
		logic [SUM_W-1:0]        sq_sum[CH_COUNT];
		report_t                 pending_reports[$];
		int                      errors;

		function new();
			sat_high   = 10'd1013;
			sat_low    = 10'd10;
			ignore_len = 8'd1;
			rms        = 1'b0;
			top_idx[0] = 3'd2;
			top_idx[1] = 3'd4;
			errors     = 0;
			for (int c = 0; c < CH_COUNT; c++) begin
				ground[c]     = 10'd512;
				range_idx[c]  = '0;
				saved_idx[c]  = '0;
				sat_count[c]  = '0;
				skip_count[c] = '0;
				max_seen[c]   = '0;
				min_seen[c]   = ADC_BITS_DEF'(ADC_MAX);
				sum[c]        = '0;
				sq_sum[c]     = '0;
			end
		endfunction

		function void note_config(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
			CFG_SAT_HIGH:  sat_high   = v[SAT_W-1:0];
			CFG_SAT_LOW:   sat_low    = v[SAT_W-1:0];
			CFG_IGNORE:    ignore_len = v[IGN_W-1:0];
			CFG_RMS_MODE:  rms        = v[0];
			CFG_HV_TOP:    top_idx[0] = v[IDX_W-1:0];
			CFG_FB_TOP:    top_idx[1] = v[IDX_W-1:0];
			CFG_HV_GROUND: ground[0]  = v[GND_W-1:0];
			CFG_FB_GROUND: ground[1]  = v[GND_W-1:0];
			default: ;
			endcase
		endfunction

		// take a new attenuator index only when it does not pass the top one
		function void move_index(int c, logic [IDX_W:0] idx);
			if (idx <= {1'b0, top_idx[c]})
				range_idx[c] = idx[IDX_W-1:0];
		endfunction

		function void note_input(logic [REQ_W-1:0] req, logic ch,
				logic [ADC_BITS_DEF-1:0] smp);
			logic [GND_W-1:0] dev;
			logic [PK_W-1:0]  pk[CH_COUNT];
			report_t          rep;
			case (req)
			REQ_SAMPLE: begin
				if (smp > sat_high || smp < sat_low) begin
					// count a saturation, then swallow the next ignore_len ones after it
					if (skip_count[ch] == 0) begin
						if (sat_count[ch] != 8'd255)
							sat_count[ch]++;
						if (range_idx[ch] != 0)
							move_index(ch, (IDX_W+1)'(range_idx[ch]) - 1'b1);
						skip_count[ch] = ignore_len;
					end else begin
						skip_count[ch]--;
					end
				end else if (rms) begin
					dev = (smp >= ground[ch]) ? smp - ground[ch] : ground[ch] - smp;
					sq_sum[ch] += SUM_W'(dev) * SUM_W'(dev);
					sum[ch]    += SUM_W'(smp);
				end else begin
					if (smp > max_seen[ch])
						max_seen[ch] = smp;
					if (smp < min_seen[ch])
						min_seen[ch] = smp;
				end
			end
			REQ_BEGIN: begin
				for (int c = 0; c < CH_COUNT; c++) begin
					saved_idx[c] = range_idx[c];
					move_index(c, {1'b0, top_idx[c]});
				end
			end
			REQ_OPEN: begin
				for (int c = 0; c < CH_COUNT; c++) begin
					sat_count[c]  = '0;
					skip_count[c] = '0;
					if (rms) begin
						sum[c]    = '0;
						sq_sum[c] = '0;
					end else begin
						min_seen[c] = ADC_BITS_DEF'(ADC_MAX);
						max_seen[c] = '0;
					end
				end
			end
			REQ_CLOSE: begin
				// one report per channel, then step up where the swing is small
				for (int c = 0; c < CH_COUNT; c++) begin
					if (rms || max_seen[c] < min_seen[c])
						pk[c] = '0;
					else
						pk[c] = PK_W'(64 * (max_seen[c] - min_seen[c]));
					rep.out_channel  = c[0];
					rep.peak_to_peak = pk[c];
					rep.sample_sum   = sum[c];
					rep.square_sum   = sq_sum[c];
					if (sat_count[c] != 0)
						rep.range_report = -((sat_count[c] > 8'd128) ? 8'd128 : sat_count[c]);
					else
						rep.range_report = {{(REP_W-IDX_W){1'b0}}, range_idx[c]};
					rep.last = (c == CH_COUNT - 1);
					pending_reports.push_back(rep);
				end
				for (int c = 0; c < CH_COUNT; c++) begin
					if (pk[c] < SMALL_PK)
						move_index(c, (IDX_W+1)'(range_idx[c]) + 1'b1);
				end
			end
			REQ_FINISH: begin
				for (int c = 0; c < CH_COUNT; c++)
					move_index(c, {1'b0, saved_idx[c]});
			end
			default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [SUM_W-1:0] want,
				logic [SUM_W-1:0] got);
			if (got !== want) begin
				errors++;
				// keep the log short when many reports go wrong
				if (errors <= LOG_LIMIT)
					$display("%0t: %s mismatch, expected %0h, actual %0h",
						$time, name, want, got);
			end
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (pending_reports.size() == 0) begin
				errors++;
				if (errors <= LOG_LIMIT)
					$display("%0t: report for channel %0d with no expectation, actual %0h",
						$time, got.out_channel, got);
				return;
			end
			want = pending_reports.pop_front();
			compare_field("out_channel", want.out_channel, got.out_channel);
			compare_field("peak_to_peak", want.peak_to_peak, got.peak_to_peak);
			compare_field("sample_sum", want.sample_sum, got.sample_sum);
			compare_field("square_sum", want.square_sum, got.square_sum);
			compare_field("range_report", SUM_W'(unsigned'(want.range_report)),
				SUM_W'(unsigned'(got.range_report)));
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_DATA_W-1:0]     s_axis_tdata = '0;
	logic [REQ_W:0]           s_axis_tuser = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [REPORT_DATA_W-1:0] m_axis_tdata;
	logic [0:0]               m_axis_tuser;
	logic                     m_axis_tlast;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	cfg_idx_t                 cfg_index = CFG_SAT_HIGH;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	meter_scoreboard sb;
	bit              sender_burst;
	bit              receiver_burst;
	int              items_sent;

	autorange_amplitude_meter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic draw_chan();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [ADC_BITS_DEF-1:0] draw_code();
		return ADC_BITS_DEF'($urandom_range(0, ADC_MAX));
	endfunction

	// present one request and hold it until the meter takes it
	task automatic send_item(logic [REQ_W-1:0] req, logic ch, logic [ADC_BITS_DEF-1:0] smp);
		int gap;
		gap = draw_gap(sender_burst);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'(smp);
		s_axis_tuser  <= {ch, req};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		sb.note_input(req, ch, smp);
		items_sent++;
	endtask

	// stop sending until every expected report is out, then let the pipe empty
	task automatic drain(int extra);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_reports.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_config(cfg_idx_t idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.note_config(idx, CFG_DATA_W'(value));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(int hi, int lo, int ign, int rms_on, int top0, int top1,
			int g0, int g1);
		write_config(CFG_SAT_HIGH, hi);
		write_config(CFG_SAT_LOW, lo);
		write_config(CFG_IGNORE, ign);
		write_config(CFG_RMS_MODE, rms_on);
		write_config(CFG_HV_TOP, top0);
		write_config(CFG_FB_TOP, top1);
		write_config(CFG_HV_GROUND, g0);
		write_config(CFG_FB_GROUND, g1);
	endtask

	task automatic random_settings(bit rms_on);
		int hi, lo, ign;
		case ($urandom_range(0, 5))
		0: hi = ADC_MAX;
		1: hi = 0;
		default: hi = $urandom_range(900, ADC_MAX);
		endcase
		case ($urandom_range(0, 5))
		0: lo = 0;
		1: lo = ADC_MAX;
		default: lo = $urandom_range(0, 100);
		endcase
		case ($urandom_range(0, 5))
		0: ign = 0;
		1: ign = 255;
		default: ign = $urandom_range(0, 3);
		endcase
		apply_settings(hi, lo, ign, rms_on, $urandom_range(0, 7), $urandom_range(0, 7),
			$urandom_range(0, ADC_MAX), $urandom_range(0, ADC_MAX));
	endtask

	// mostly values around a window center, plus band edges and full-scale codes
	function automatic logic [ADC_BITS_DEF-1:0] draw_sample(int center, int spread);
		int v;
		int pick;
		pick = (spread <= 30 && $urandom_range(0, 7) != 0) ? 19 : $urandom_range(0, 19);
		case (pick)
		0: v = $urandom_range(0, ADC_MAX);
		1: v = 0;
		2: v = ADC_MAX;
		3: v = int'(sb.sat_low);
		4: v = int'(sb.sat_high);
		5: v = int'(sb.sat_low) - 1;
		6: v = int'(sb.sat_high) + 1;
		default: v = center + int'($urandom_range(0, 2 * spread)) - spread;
		endcase
		if (v < 0)
			v = 0;
		if (v > ADC_MAX)
			v = ADC_MAX;
		return v[ADC_BITS_DEF-1:0];
	endfunction

	// one measurement: an optional begin, one to three windows of samples, an optional finish, with some noise
	task automatic run_measurement();
		int center, spread;
		sender_burst   = ($urandom_range(0, 3) == 0);
		receiver_burst = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 4) != 0)
			send_item(REQ_BEGIN, draw_chan(), draw_code());
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 7) != 0)
				send_item(REQ_OPEN, draw_chan(), draw_code());
			center = $urandom_range(0, ADC_MAX);
			spread = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 30) : 600;
			repeat ($urandom_range(0, 24)) begin
				if ($urandom_range(0, 19) == 0)
					send_item(REQ_W'($urandom_range(0, (1 << REQ_W) - 1)),
						draw_chan(), draw_code());
				else
					send_item(REQ_SAMPLE, draw_chan(), draw_sample(center, spread));
			end
			if ($urandom_range(0, 9) == 0)
				drain(0);
			send_item(REQ_CLOSE, draw_chan(), draw_code());
		end
		if ($urandom_range(0, 4) != 0)
			send_item(REQ_FINISH, draw_chan(), draw_code());
	endtask

	// main sequence
	initial begin : stimulus
		int target;
		sb         = new();
		items_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset settings
		send_item(REQ_CLOSE, 1'b0, 10'd0);
		send_item(REQ_BEGIN, 1'b1, 10'd1023);
		send_item(REQ_OPEN, 1'b0, 10'd0);
		send_item(REQ_SAMPLE, 1'b0, 10'd1023);
		send_item(REQ_SAMPLE, 1'b0, 10'd0);
		send_item(REQ_SAMPLE, 1'b0, 10'd0);
		send_item(REQ_SAMPLE, 1'b1, 10'd10);
		send_item(REQ_SAMPLE, 1'b1, 10'd1013);
		send_item(REQ_SAMPLE, 1'b1, 10'd9);
		send_item(REQ_SAMPLE, 1'b1, 10'd1014);
		send_item(REQ_SAMPLE, 1'b0, 10'd500);
		send_item(REQ_CLOSE, 1'b1, 10'd0);
		for (int k = int'(REQ_FINISH) + 1; k < (1 << REQ_W); k++)
			send_item(REQ_W'(k), k[0], 10'd1023);
		send_item(REQ_FINISH, 1'b0, 10'd0);
		send_item(REQ_CLOSE, 1'b0, 10'd0);
		drain(SETTLE);

		// directed rms window with grounds at both ends of the scale
		apply_settings(ADC_MAX, 0, 1, 1, 7, 0, 0, ADC_MAX);
		send_item(REQ_OPEN, 1'b0, 10'd0);
		send_item(REQ_SAMPLE, 1'b0, 10'd1023);
		send_item(REQ_SAMPLE, 1'b1, 10'd0);
		send_item(REQ_SAMPLE, 1'b0, 10'd0);
		send_item(REQ_CLOSE, 1'b0, 10'd0);
		drain(SETTLE);

		// random phases, the first two on extreme settings
		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 0)
				apply_settings(ADC_MAX, 0, 0, 0, 0, 7, 0, ADC_MAX);
			else if (phase == 1)
				apply_settings(0, ADC_MAX, 255, 1, 7, 0, ADC_MAX, 0);
			else
				random_settings(phase[0]);
			target = items_sent + PHASE_LEN;
			while (items_sent < target)
				run_measurement();
			drain(SETTLE);
		end

		// saturation flood: fill one counter, pass the report clamp on the other
		apply_settings(900, 100, 0, 0, 7, 7, 512, 512);
		sender_burst = ($urandom_range(0, 1) == 0);
		send_item(REQ_BEGIN, 1'b0, 10'd0);
		send_item(REQ_OPEN, 1'b0, 10'd0);
		for (int k = 0; k < 410; k++)
			send_item(REQ_SAMPLE, (k >= 270), ADC_BITS_DEF'(($urandom_range(0, 1) == 0) ?
				$urandom_range(0, 99) : $urandom_range(901, ADC_MAX)));
		send_item(REQ_CLOSE, 1'b0, 10'd0);
		send_item(REQ_FINISH, 1'b0, 10'd0);
		drain(SETTLE);

		if (sb.errors == 0 && sb.pending_reports.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// receiver with random stalls between reports
	initial begin : receiver
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap(receiver_burst);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// check each report transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_report(report_t'({m_axis_tlast, m_axis_tuser[0], m_axis_tdata}));
	end

	// end the run when no transaction moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

endmodule

@@ autorange_amplitude_meter_unit.f @@
rtl/aam_pkg.sv
rtl/autorange_amplitude_meter_unit.sv
bench/tb_top.sv
